/* src/region_table_best_fit_engine_unit_macros.svh */
// Assertion macros for the region table engine.
`ifndef REGION_TABLE_BEST_FIT_ENGINE_UNIT_MACROS_SVH
`define REGION_TABLE_BEST_FIT_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RT_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define RT_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define RT_ASSERT(label, cond, msg)
`define RT_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

/* src/rtbf_pkg.sv */
// Shared types and constants for the region table engine.
package rtbf_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_REMOVE = 3'd1;
	localparam logic [2:0] FN_BEST = 3'd2;
	localparam logic [2:0] FN_SPLIT = 3'd3;
	localparam logic [2:0] FN_FIND = 3'd4;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic [4:0]  kind;
	} entry_t;

	// per-cycle command to every cell
	typedef struct packed {
		logic           rotate;
		logic           load;
		logic           drop;
		entry_t         data;
	} cell_ctl_t;
endpackage

/* src/rtbf_cell.sv */
// One table slot; in rotate mode it takes its neighbor's entry.
module rtbf_cell import rtbf_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    prev,
	input  entry_t    next_in,
	output entry_t    q
);
	entry_t ent_q;
	assign q = ent_q;
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ent_q <= ctl.data;
		end else if (ctl.drop) begin
			ent_q <= next_in;
		end else if (ctl.rotate) begin
			ent_q <= prev;
		end
	end
endmodule

/* src/region_table_best_fit_engine_unit.sv */
// Top level: region table as a ring of cells with a rotating scan controller.
// Each request rotates the ring once, with cell 0 inspected at each step, and then
// registers its result in ST_DONE; remove adds a drop state (ST_SHIFT) before it.
// The input reopens the cycle after the result is taken; one item at a time.
// arst_n clears control and the entry count; entry contents are not cleared.
`include "region_table_best_fit_engine_unit_macros.svh"
module region_table_best_fit_engine_unit import rtbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata, // func[2:0] reg_start[34:3] reg_size[66:35] reg_kind[71:67] entry_index[76:72]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata  // status[0] result_index[5:1] found_start[37:6]
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t st_q;
	logic [2:0] fn_q;
	logic [31:0] st_in_q, sz_in_q;
	logic [4:0] kd_q;
	logic [IDX_W-1:0] ix_q, pos_q, best_q, tgt_q;
	logic [CNT_W-1:0] cnt_q;
	logic have_q, ok_q;
	logic [31:0] bsize_q, fstart_q;
	entry_t app_q;
	logic [39:0] out_q;
	logic ov_q;
	logic [4:0] res_idx;

	entry_t cq [TABLE_DEPTH];
	cell_ctl_t ctl [TABLE_DEPTH];
	entry_t c0;
	logic live, match, tail;
	assign c0 = cq[0];
	assign live = CNT_W'(pos_q) < cnt_q;
	assign match = live && (c0.kind == kd_q);
	assign tail = pos_q == IDX_W'(TABLE_DEPTH - 1);
	assign s_tready = (st_q == ST_IDLE) && !ov_q;
	assign m_tvalid = ov_q;
	assign m_tdata = out_q;
	assign res_idx = (fn_q == FN_ADD || fn_q == FN_SPLIT) ? 5'(cnt_q - 1'b1)
		: (fn_q == FN_BEST || fn_q == FN_FIND) ? 5'(best_q) : 5'd0;

	// position pos_q is in cell 0; when the split target sits there, its updated
	// entry is loaded into the last cell in place of the rotation.
	logic split_hit, split_ok;
	assign split_hit = (fn_q == FN_SPLIT) && (pos_q == ix_q);
	assign split_ok = split_hit && live && (c0.size >= sz_in_q)
		&& (cnt_q < CNT_W'(TABLE_DEPTH - 1));

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			always_comb begin
				ctl[g] = '0;
				ctl[g].rotate = st_q == ST_SCAN;
				ctl[g].drop = (st_q == ST_SHIFT) && (IDX_W'(g) >= tgt_q);
				if (g == TABLE_DEPTH - 1) begin
					if (st_q == ST_SCAN && split_ok) begin
						ctl[g].load = 1'b1;
						ctl[g].data = '{start: c0.start + sz_in_q,
							size: c0.size - sz_in_q, kind: c0.kind};
					end
				end
				if (st_q == ST_DONE && fn_q == FN_ADD && ok_q
					&& IDX_W'(g) == IDX_W'(cnt_q - 1'b1)) begin
					ctl[g].load = 1'b1;
					ctl[g].data = app_q;
				end
				if (st_q == ST_DONE && fn_q == FN_SPLIT && ok_q
					&& IDX_W'(g) == IDX_W'(cnt_q - 1'b1)) begin
					ctl[g].load = 1'b1;
					ctl[g].data = app_q;
				end
			end
			rtbf_cell u_cell (
				.clk(clk), .ctl(ctl[g]),
				.prev(cq[(g + 1) % TABLE_DEPTH]),
				.next_in(cq[(g + 1) % TABLE_DEPTH]),
				.q(cq[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && m_tready) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						fn_q <= s_tdata[2:0];
						st_in_q <= s_tdata[34:3];
						sz_in_q <= s_tdata[66:35];
						kd_q <= s_tdata[71:67];
						ix_q <= s_tdata[72 +: IDX_W];
						pos_q <= '0;
						have_q <= 1'b0;
						ok_q <= 1'b0;
						best_q <= '0;
						fstart_q <= '0;
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pos_q <= pos_q + 1'b1;
					unique case (fn_q)
						FN_BEST: if (match && c0.size > sz_in_q
							&& (!have_q || c0.size < bsize_q)) begin
							have_q <= 1'b1;
							best_q <= pos_q;
							bsize_q <= c0.size;
						end
						FN_FIND: if (match && !have_q && pos_q >= ix_q) begin
							have_q <= 1'b1;
							best_q <= pos_q;
							fstart_q <= c0.start;
						end
						FN_SPLIT: if (split_ok) begin
							have_q <= 1'b1;
							app_q <= '{start: c0.start, size: sz_in_q, kind: c0.kind};
						end
						default: ;
					endcase
					if (tail) begin
						st_q <= (fn_q == FN_REMOVE && CNT_W'(ix_q) < cnt_q)
							? ST_SHIFT : ST_DONE;
						tgt_q <= ix_q;
						unique case (fn_q)
							FN_ADD: begin
								app_q <= '{start: st_in_q, size: sz_in_q, kind: kd_q};
								if (cnt_q < CNT_W'(TABLE_DEPTH - 1)) begin
									ok_q <= 1'b1;
									cnt_q <= cnt_q + 1'b1;
								end
							end
							FN_REMOVE: if (CNT_W'(ix_q) < cnt_q) begin
								ok_q <= 1'b1;
								cnt_q <= cnt_q - 1'b1;
							end
							FN_SPLIT: if (have_q || split_ok) begin
								ok_q <= 1'b1;
								cnt_q <= cnt_q + 1'b1;
							end
							FN_BEST, FN_FIND: ok_q <= have_q
								|| (fn_q == FN_FIND && match && pos_q >= ix_q)
								|| (fn_q == FN_BEST && match && c0.size > sz_in_q);
							default: ;
						endcase
					end
				end
				ST_SHIFT: begin
					// one drop moves every entry at or past the target down once
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					st_q <= ST_IDLE;
					ov_q <= 1'b1;
					out_q <= ok_q
						? {2'b00, (fn_q == FN_FIND) ? fstart_q : 32'd0, res_idx, 1'b0}
						: 40'd1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`RT_ASSERT(a_cnt_max, cnt_q < CNT_W'(TABLE_DEPTH), "count overflow")
	`RT_ASSERT(a_no_accept_busy, !(st_q != ST_IDLE && s_tready), "ready while busy")
	`RT_ASSERT_IMPL(a_done_out, st_q == ST_DONE, m_tvalid, "result not posted")
endmodule

/* sim/region_table_best_fit_engine_unit_test.sv */
// Testbench for the region table engine: random table operations checked against a built-in predictor.
module region_table_best_fit_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rtbf_pkg::*;

	typedef struct {
		bit        status;
		bit [4:0]  index;
		bit [31:0] start;
	} region_result_t;

	class region_table_board;
		bit [31:0] starts[TABLE_DEPTH];
		bit [31:0] sizes[TABLE_DEPTH];
		bit [4:0]  kinds[TABLE_DEPTH];
		int unsigned count;
		region_result_t pending[$];
		int mismatches;
		int checked;

		function int append(bit [31:0] s, bit [31:0] z, bit [4:0] k);
			if (count >= TABLE_DEPTH - 1)
				return -1;
			starts[count] = s;
			sizes[count] = z;
			kinds[count] = k;
			count++;
			return count - 1;
		endfunction

		function void note_item(bit [2:0] fn, bit [31:0] s, bit [31:0] z, bit [4:0] k,
				bit [4:0] idx);
			region_result_t r;
			int slot;
			bit have;
			int best;
			bit [31:0] os;
			r = '{1'b1, 5'd0, 32'd0};
			case (fn)
				FN_ADD: begin
					slot = append(s, z, k);
					if (slot >= 0)
						r = '{1'b0, slot[4:0], 32'd0};
				end
				FN_REMOVE: begin
					if (idx < count) begin
						count--;
						for (int i = idx; i < count; i++) begin
							starts[i] = starts[i + 1];
							sizes[i] = sizes[i + 1];
							kinds[i] = kinds[i + 1];
						end
						r.status = 1'b0;
					end
				end
				FN_BEST: begin
					have = 0;
					best = 0;
					for (int i = 0; i < count; i++)
						if (kinds[i] == k && sizes[i] > z && (!have || sizes[i] < sizes[best])) begin
							have = 1;
							best = i;
						end
					if (have)
						r = '{1'b0, best[4:0], 32'd0};
				end
				FN_SPLIT: begin
					if (idx < count && sizes[idx] >= z) begin
						os = starts[idx];
						slot = append(os, z, kinds[idx]);
						if (slot >= 0) begin
							sizes[idx] = sizes[idx] - z;
							starts[idx] = os + z;
							r = '{1'b0, slot[4:0], 32'd0};
						end
					end
				end
				FN_FIND: begin
					for (int i = idx; i < count; i++)
						if (kinds[i] == k) begin
							r = '{1'b0, i[4:0], starts[i]};
							break;
						end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(bit [39:0] d);
			region_result_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no item pending: %h", d);
				return;
			end
			e = pending.pop_front();
			if (d[0] !== e.status || d[5:1] !== e.index || d[37:6] !== e.start) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected status %0d index %0d start %h, got %0d %0d %h",
						e.status, e.index, e.start, d[0], d[5:1], d[37:6]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	region_table_board board;
	int  cycles;
	int  sent;
	bit  idle_send;
	bit  idle_recv;
	bit  hold_recv;

	region_table_best_fit_engine_unit u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic send_item(bit [2:0] fn, bit [31:0] s, bit [31:0] z, bit [4:0] k,
			bit [4:0] idx);
		while (!idle_send && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'd0, idx, k, z, s, fn};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_item(fn, s, z, k, idx);
		sent++;
	endtask

	function automatic bit [31:0] pick_size();
		case ($urandom_range(3))
			0: return $urandom_range(16);
			1: return $urandom_range(4096);
			2: return 32'hFFFF_FFF0 + $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_item();
		bit [2:0] fn;
		int c;
		c = $urandom_range(99);
		if (c < 30)
			fn = FN_ADD;
		else if (c < 45)
			fn = FN_REMOVE;
		else if (c < 63)
			fn = FN_BEST;
		else if (c < 80)
			fn = FN_SPLIT;
		else if (c < 96)
			fn = FN_FIND;
		else
			fn = 3'($urandom_range(5, 7));
		send_item(fn, $urandom, pick_size(), $urandom_range(3) == 0 ? 5'($urandom) :
			5'($urandom_range(3)), $urandom_range(4) == 0 ? 5'($urandom) :
			5'($urandom_range(board.count > 0 ? board.count : 0)));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			m_tready <= !hold_recv && (idle_recv || $urandom_range(99) >= 20);
		end
	end

	initial begin
		board = new();
		cycles = 0;
		sent = 0;
		idle_send = 0;
		idle_recv = 0;
		hold_recv = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty table, extremes, fill to full, split edges
		send_item(FN_REMOVE, 0, 0, 0, 0);
		send_item(FN_BEST, 0, 0, 0, 0);
		send_item(FN_SPLIT, 0, 0, 0, 0);
		send_item(FN_FIND, 0, 0, 0, 0);
		send_item(3'd5, '1, '1, '1, '1);
		send_item(3'd7, 0, 0, 0, 0);
		send_item(FN_ADD, 32'hFFFF_FFF0, 32'h20, 5'd31, 5'd31);
		send_item(FN_ADD, 32'h0, '1, 5'd0, 0);
		send_item(FN_ADD, 32'h100, 32'h20, 5'd31, 0);
		send_item(FN_BEST, 0, 32'h1F, 5'd31, 0);
		send_item(FN_BEST, 0, 32'h20, 5'd31, 0);
		send_item(FN_BEST, 0, '1, 5'd0, 0);
		send_item(FN_SPLIT, 0, 32'h20, 0, 5'd0);
		send_item(FN_SPLIT, 0, 32'h21, 0, 5'd2);
		send_item(FN_SPLIT, 0, 32'h20, 0, 5'd2);
		send_item(FN_FIND, 0, 0, 5'd31, 5'd1);
		send_item(FN_FIND, 0, 0, 5'd31, 5'd31);
		send_item(FN_REMOVE, 0, 0, 0, 5'd4);
		send_item(FN_REMOVE, 0, 0, 0, 5'd0);
		while (board.count < TABLE_DEPTH - 1)
			send_item(FN_ADD, $urandom, pick_size(), 5'($urandom), 0);
		send_item(FN_ADD, '1, '1, '1, '1);
		send_item(FN_SPLIT, 0, 0, 0, 5'd30);
		send_item(FN_REMOVE, 0, 0, 0, 5'd30);
		send_item(FN_REMOVE, 0, 0, 0, 5'd31);
		// random, with a long receiver hold-off
		for (int n = 0; n < 650; n++) begin
			if (n == 100)
				hold_recv = 1;
			idle_send = (n >= 300 && n < 400);
			idle_recv = idle_send;
			random_item();
		end
		s_tvalid <= 1'b0;
		while (board.pending.size() > 0 && cycles < 2000000)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Ran %0d table operations, %0d results checked, incl. full table and stalls.",
			sent, board.checked);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		hold_recv = 0;
		wait (hold_recv);
		repeat (400) @(posedge clk);
		hold_recv = 0;
	end

	initial begin
		wait (cycles >= 2000000);
		$display("Mismatches found");
		$finish;
	end
endmodule
